>>> rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search unit.
// Beat payloads, register indexes, controller states and command/status groups.
// No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

  // configuration register indexes
  localparam logic CFG_ORDER = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam int CFG_DATA_W = 8;

  // action codes
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  typedef struct packed {
    logic               action;
    logic [6:0]         index;
    logic signed [31:0] value;
  } stbs_in_t;

  typedef struct packed {
    logic       found;
    logic [6:0] position;
  } stbs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EMPTY
  } stbs_state_t;

  // controller -> datapath
  typedef struct packed {
    logic write;    // store the accepted beat into the table
    logic load;     // start a search from the accepted beat
    logic step;     // narrow the span and fetch the next probe
    logic publish;  // load the output register
    logic found;    // value of found when publishing
  } stbs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;      // clamped count is zero
    logic hit;        // current probe equals the key
    logic span_done;  // span would be empty after this probe
  } stbs_status_t;

endpackage

>>> rtl/stbs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/stbs_ctrl.sv
// Search controller: sequences table writes, probe iterations and result hand-off.
// Depends on stbs_pkg.
`timescale 1ns / 1ps

module stbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_action,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  stbs_pkg::stbs_status_t status,
  output stbs_pkg::stbs_cmd_t    cmd
);
  import stbs_pkg::*;

  stbs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_action == ACT_SEARCH) begin
            if (status.empty) begin
              state_nxt = ST_EMPTY;
            end else begin
              cmd.load  = 1'b1;
              state_nxt = ST_PROBE;
            end
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (!(status.hit || status.span_done)) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          // last probe: hold it until the output register is free
          cmd.publish = 1'b1;
          cmd.found   = status.hit;
          state_nxt   = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/stbs_datapath.sv
// Search datapath: config registers, entry table, span registers, compare and output register.
// Depends on stbs_pkg and stbs_ram.
`timescale 1ns / 1ps

module stbs_datapath #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  stbs_pkg::stbs_in_t                in_data,
  output stbs_pkg::stbs_out_t               out_data,
  input  stbs_pkg::stbs_cmd_t               cmd,
  output stbs_pkg::stbs_status_t            status
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  logic              order_desc_r;
  logic [7:0]        table_count_r;
  logic [CW-1:0]     count_c;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     end_r, end_nxt;
  logic [AW-1:0]     mid_r, mid_nxt, mid_start, raddr;
  logic [CW:0]       span_sum;
  logic signed [31:0] key_r;
  logic [31:0]       rdata;
  logic signed [31:0] probe;
  logic              go_left;
  logic              ram_we;
  stbs_out_t         out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_desc_r  <= 1'b0;
      table_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ORDER: order_desc_r  <= cfg_data[0];
        CFG_COUNT: table_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // count above the table depth searches the whole table
  assign count_c = (32'(table_count_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(table_count_r);

  assign mid_start = AW'((count_c - CW'(1)) >> 1);

  assign probe   = $signed(rdata);
  assign go_left = order_desc_r ? (key_r > probe) : (key_r < probe);

  // span kept as [lo, end); end is one past the old hi
  assign lo_nxt   = go_left ? lo_r : (CW'(mid_r) + CW'(1));
  assign end_nxt  = go_left ? CW'(mid_r) : end_r;
  assign span_sum = (CW + 1)'(lo_nxt) + (CW + 1)'(end_nxt) - (CW + 1)'(1);
  assign mid_nxt  = AW'(span_sum >> 1);

  assign status.empty     = (count_c == '0);
  assign status.hit       = (key_r == probe);
  assign status.span_done = (lo_nxt >= end_nxt);

  // when no step is taken the current probe is re-read so rdata holds
  always_comb begin
    if (cmd.load) begin
      raddr = mid_start;
    end else if (cmd.step) begin
      raddr = mid_nxt;
    end else begin
      raddr = mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r  <= '0;
      end_r <= count_c;
      mid_r <= mid_start;
      key_r <= in_data.value;
    end else if (cmd.step) begin
      lo_r  <= lo_nxt;
      end_r <= end_nxt;
      mid_r <= mid_nxt;
    end
    if (cmd.publish) begin
      out_r.found    <= cmd.found;
      out_r.position <= cmd.found ? 7'(mid_r) : 7'd0;
    end
  end

  assign ram_we = cmd.write && (32'(in_data.index) < TABLE_DEPTH);

  stbs_ram #(
    .WIDTH(32),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(in_data.index)),
    .wdata(in_data.value),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_data = out_r;

endmodule

>>> rtl/sorted_table_binary_search_unit.sv
// Sorted table binary search unit: top level joining controller and datapath.
// Depends on stbs_pkg, stbs_ctrl, stbs_datapath (and stbs_ram below it).
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall / in_data): a beat with action write stores
//   value at entry index and gives no result; a beat with action search looks up
//   value among the first table_count entries and gives one result beat.
//   Output channel (out_valid / out_stall / out_data): found and position.
//   Config port: cfg_we with cfg_index 0 sets order_descending, 1 sets table_count;
//   write only while the unit is idle.
//   Timing: after a write a new beat may follow at once. A search issues the first
//   table read when it is accepted, then probes the table; each probe is a
//   registered table read and a 32-bit compare fed back into the next address,
//   up to floor(log2(N))+1 probes for N entries. A search of an empty table
//   makes no probe. The result is loaded into the output register from the last
//   probe; in_stall is high while a search runs.
//   The output register lets a new beat be accepted while a result waits. When
//   out_stall holds a result, a following search stops on its last probe until
//   the register frees.
//   Reset (rst_n low, synchronous) clears both config registers and drops out_valid;
//   table entries are not cleared and must be written before they are searched.

module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  stbs_pkg::stbs_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output stbs_pkg::stbs_out_t             out_data,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import stbs_pkg::*;

  stbs_cmd_t    cmd;
  stbs_status_t status;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_action(in_data.action),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

>>> rtl/stbs_checker.sv
// Port-level checks for the sorted table binary search unit, bound to the top level.
// Depends on stbs_pkg and sorted_table_binary_search_unit.
`timescale 1ns / 1ps

module stbs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input stbs_pkg::stbs_in_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input stbs_pkg::stbs_out_t             out_data
);
  import stbs_pkg::*;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == 7'd0)
    else $error("miss with non-zero position");

  // an accepted search keeps the input side busy
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == ACT_SEARCH |=> in_stall)
    else $error("search beat did not stall the input");

  // results come only out of a running search
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a running search");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
